// ===== sv/sfr_pkg.sv =====
// Shared types and constants for the stuffed frame receiver.
`timescale 1ns / 1ps
package sfr_pkg;

	localparam logic [7:0]  START_BYTE = 8'h7F;
	localparam logic [15:0] CRC_SEED   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h8005;
	localparam logic [15:0] CRC_TOP    = 16'h8000;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_ADDR  = 3'd1,
		PH_LEN   = 3'd2,
		PH_DATA  = 3'd3,
		PH_CRCLO = 3'd4,
		PH_CRCHI = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADCRC  = 2'd1,
		ST_STUFF   = 2'd2,
		ST_NOSTART = 2'd3
	} status_t;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// One result beat as it leaves the parser
	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       is_last;
		status_t    status;
		logic [6:0] node_id;
		logic       sequence_bit;
		logic [7:0] payload_length;
	} res_t;

endpackage

// ===== sv/sfr_crc16.sv =====
// CRC-16 (poly 0x8005, MSB first) update over one byte.
`timescale 1ns / 1ps
module sfr_crc16
	import sfr_pkg::*;
(
	input  logic [15:0] crc,
	input  logic [7:0]  data,
	output logic [15:0] crc_next
);

	// Shift the byte through eight bit steps
	always_comb begin
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule

// ===== sv/sfr_parse.sv =====
// Frame state machine: unstuffing, header capture, CRC check and result build.
`timescale 1ns / 1ps
module sfr_parse
	import sfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic [7:0] b,
	output logic       res_valid,
	output res_t       res
);

	phase_t      phase_q, phase_d;
	logic        esc_q, esc_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  remain_q, remain_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  addr_q, addr_d;
	logic [7:0]  crclo_q, crclo_d;
	logic [15:0] crc_upd;
	logic        is_start;
	logic        hunting;
	logic        stuff_err;
	logic        take;
	logic [7:0]  remain_dec;

	sfr_crc16 u_crc (
		.crc      (crc_q),
		.data     (b),
		.crc_next (crc_upd)
	);

	assign is_start   = (b == START_BYTE);
	assign hunting    = (phase_q == PH_HUNT) || (phase_q > PH_CRCHI);
	assign stuff_err  = esc_q && !is_start;
	// A byte goes on to the phase logic when it is plain or completes a pair
	assign take       = esc_q ? is_start : !is_start;
	assign remain_dec = remain_q - 8'd1;

	// Next state
	always_comb begin
		phase_d  = phase_q;
		esc_d    = esc_q;
		crc_d    = crc_q;
		remain_d = remain_q;
		len_d    = len_q;
		addr_d   = addr_q;
		crclo_d  = crclo_q;
		if (go) begin
			if (hunting) begin
				if (is_start) begin
					phase_d  = PH_ADDR;
					esc_d    = 1'b0;
					crc_d    = CRC_SEED;
					remain_d = 8'd0;
				end else begin
					phase_d = PH_HUNT;
				end
			end else if (stuff_err) begin
				esc_d   = 1'b0;
				phase_d = PH_HUNT;
			end else if (!take) begin
				esc_d = 1'b1;
			end else begin
				esc_d = 1'b0;
				case (phase_q)
					PH_ADDR: begin
						addr_d  = b;
						crc_d   = crc_upd;
						phase_d = PH_LEN;
					end
					PH_LEN: begin
						len_d    = b;
						remain_d = b;
						crc_d    = crc_upd;
						phase_d  = (b == 8'd0) ? PH_CRCLO : PH_DATA;
					end
					PH_DATA: begin
						crc_d    = crc_upd;
						remain_d = remain_dec;
						if (remain_dec == 8'd0) begin
							phase_d = PH_CRCLO;
						end
					end
					PH_CRCLO: begin
						crclo_d = b;
						phase_d = PH_CRCHI;
					end
					default: begin
						phase_d = PH_HUNT;
					end
				endcase
			end
		end
	end

	// Result beat
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (go) begin
			if (hunting) begin
				if (!is_start) begin
					res_valid  = 1'b1;
					res.kind    = KIND_REPORT;
					res.is_last = 1'b1;
					res.status  = ST_NOSTART;
				end
			end else if (stuff_err) begin
				res_valid   = 1'b1;
				res.kind    = KIND_REPORT;
				res.is_last = 1'b1;
				res.status  = ST_STUFF;
			end else if (take) begin
				case (phase_q)
					PH_DATA: begin
						res_valid          = 1'b1;
						res.kind           = KIND_DATA;
						res.data_byte      = b;
						res.status         = ST_OK;
						res.node_id        = addr_q[6:0];
						res.sequence_bit   = addr_q[7];
						res.payload_length = len_q;
					end
					PH_CRCHI: begin
						res_valid          = 1'b1;
						res.kind           = KIND_REPORT;
						res.is_last        = 1'b1;
						res.status         = ({b, crclo_q} == crc_q) ? ST_OK : ST_BADCRC;
						res.node_id        = addr_q[6:0];
						res.sequence_bit   = addr_q[7];
						res.payload_length = len_q;
					end
					default: begin
						res_valid = 1'b0;
					end
				endcase
			end
		end
	end

	// Hold frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			esc_q    <= 1'b0;
			crc_q    <= CRC_SEED;
			remain_q <= 8'd0;
			len_q    <= 8'd0;
			addr_q   <= 8'd0;
			crclo_q  <= 8'd0;
		end else begin
			phase_q  <= phase_d;
			esc_q    <= esc_d;
			crc_q    <= crc_d;
			remain_q <= remain_d;
			len_q    <= len_d;
			addr_q   <= addr_d;
			crclo_q  <= crclo_d;
		end
	end

endmodule

// ===== sv/stuffed_frame_receiver_crc16.sv =====
// Top level of the byte-stuffed frame receiver with CRC-16 check.
//
// Usage: raw serial bytes enter on rx_byte with in_valid / in_ready; one beat
// carries one byte. Results leave on out_valid / out_ready: payload bytes
// (kind 0) as they are unstuffed, and reports (kind 1, is_last set) for
// frame end (ok or bad CRC), stuffing errors and bytes seen outside a frame.
// Bytes that open a frame, carry the header or low CRC byte, or are the
// first half of a stuffed 0x7F pair give no result.
// Path: a byte is captured in the input register, passes the frame logic
// when that register moves on, and its result is loaded into the output
// register, from which it can be taken.
// Throughput: one byte per cycle while the output is not stalled; the CRC
// byte update and state step are combinational between the registers.
// Stall: when out_ready is low and a result is held, the input register
// fills and in_ready drops; nothing is lost or repeated. Bytes that give no
// result still move on while the output register is full only if it frees.
// Reset: clears the valid flags of both registers and returns the frame
// logic to hunting for the start byte with the CRC at its seed.
`timescale 1ns / 1ps
module stuffed_frame_receiver_crc16
	import sfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [7:0] data_byte,
	output logic       is_last,
	output logic [1:0] status,
	output logic [6:0] node_id,
	output logic       sequence_bit,
	output logic [7:0] payload_length
);

	logic       byte_vld_s1;
	logic [7:0] byte_s1;
	logic       out_vld_q;
	res_t       res_q;
	logic       advance;
	logic       res_valid;
	res_t       res;

	// Stage 1 moves on when the output register is free or being drained
	assign advance  = !out_vld_q || out_ready;
	assign in_ready = !byte_vld_s1 || advance;

	// Capture incoming beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_vld_s1 <= 1'b0;
		end else if (in_ready) begin
			byte_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	sfr_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (byte_vld_s1 && advance),
		.b         (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= byte_vld_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && byte_vld_s1 && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_vld_q;
	assign kind           = res_q.kind;
	assign data_byte      = res_q.data_byte;
	assign is_last        = res_q.is_last;
	assign status         = res_q.status;
	assign node_id        = res_q.node_id;
	assign sequence_bit   = res_q.sequence_bit;
	assign payload_length = res_q.payload_length;

endmodule
